// ----- rtl/core/apsc_pkg.sv -----
// ----------------------------------------------------------------------------
// apsc_pkg: shared types and constants of the peak/valley step counter
// Register indexes, reset values, queue entry layout and the back-end states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package apsc_pkg;

    // Field widths
    localparam int TIME_W  = 32;
    localparam int ACCEL_W = 16;
    localparam int SUM_W   = 32;
    localparam int MAG_W   = 16;
    localparam int TOTAL_W = 32;
    localparam int CNT_W   = 8;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    // Square root: one result bit per iteration
    localparam int ROOT_STEPS = SUM_W / 2;
    localparam int ROOT_CNT_W = $clog2(ROOT_STEPS);

    // Queue between front and back
    localparam int Q_DEPTH_DEF = 2;

    // Register reset values
    localparam logic [CFG_W-1:0] SWING_THR_RST = 16'd100;
    localparam logic [CFG_W-1:0] FAST_LIM_RST  = 16'd200;
    localparam logic [CFG_W-1:0] SLOW_LIM_RST  = 16'd10000;
    localparam logic [CNT_W-1:0] CONFIRM_RST   = 8'd7;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SWING_THR = 2'd0,
        CFG_FAST_LIM  = 2'd1,
        CFG_SLOW_LIM  = 2'd2,
        CFG_CONFIRM   = 2'd3
    } t_cfg_idx;

    // One queued sample: timestamp and sum of squares
    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic [SUM_W-1:0]  sum_sq;
    } t_qentry;

    // Write side of the queue
    typedef struct packed {
        logic    valid;
        t_qentry data;
    } t_qpush;

    // Read side status of the queue
    typedef struct packed {
        logic    full;
        logic    empty;
        t_qentry head;
    } t_qstat;

    // Back-end sequencer
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_ROOT   = 4'b0010,
        S_EVAL   = 4'b0100,
        S_COMMIT = 4'b1000
    } t_back_state;

endpackage

// ----- rtl/core/accel_peak_step_counter_top.sv -----
// ----------------------------------------------------------------------------
// accel_peak_step_counter_top: peak/valley pedometer step counter
// Input channel: one timestamped three-axis sample per transfer
//   (i_in_valid / o_in_stall). Output channel: the running step total after
//   that sample, one result per sample, in order (o_out_valid / i_out_stall).
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
//   (0 swing threshold, 1 fast limit, 2 slow limit, 3 confirm count);
//   write only while no sample is in flight.
// Path from input transfer to result valid: the squaring stage, the queue,
//   the idle state that pops the queue, 16 square-root iterations, the
//   peak/valley state and the decision state.
// The step engine handles one sample at a time: it takes no new sample until
//   the bit-serial square root and the decision for the last one are done.
// The intake and the queue keep taking samples while the engine works;
//   o_in_stall rises once the queue and the squaring stage are full.
// When the receiver stalls, the result holds in the output register and the
//   engine waits after finishing its next sample.
// Reset (synchronous, active low) empties the queue, clears the detector
//   and totals and loads the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module accel_peak_step_counter_top #(
    parameter int Q_DEPTH = apsc_pkg::Q_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [apsc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [apsc_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [apsc_pkg::TIME_W-1:0]         i_time_ms,
    input  logic signed [apsc_pkg::ACCEL_W-1:0] i_accel_x,
    input  logic signed [apsc_pkg::ACCEL_W-1:0] i_accel_y,
    input  logic signed [apsc_pkg::ACCEL_W-1:0] i_accel_z,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [apsc_pkg::TOTAL_W-1:0]        o_total_steps
);
    import apsc_pkg::*;

    t_qpush q_push;
    t_qstat q_stat;
    logic   q_pop;

    // Intake and squaring
    apsc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_time_ms  (i_time_ms),
        .i_accel_x  (i_accel_x),
        .i_accel_y  (i_accel_y),
        .i_accel_z  (i_accel_z),
        .i_q_full   (q_stat.full),
        .o_push     (q_push)
    );

    // Decoupling queue
    apsc_queue #(
        .Q_DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pop   (q_pop),
        .o_stat  (q_stat)
    );

    // Step engine
    apsc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_q_stat      (q_stat),
        .o_q_pop       (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_total_steps (o_total_steps)
    );

endmodule

// ----- rtl/core/apsc_front.sv -----
// ----------------------------------------------------------------------------
// apsc_front: sample intake
// Accepts samples, squares the three axes in one register stage and pushes
// timestamp plus sum of squares into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apsc_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [apsc_pkg::TIME_W-1:0]    i_time_ms,
    input  logic signed [apsc_pkg::ACCEL_W-1:0] i_accel_x,
    input  logic signed [apsc_pkg::ACCEL_W-1:0] i_accel_y,
    input  logic signed [apsc_pkg::ACCEL_W-1:0] i_accel_z,
    input  logic                           i_q_full,
    output apsc_pkg::t_qpush               o_push
);
    import apsc_pkg::*;

    logic                    r_valid;
    logic [TIME_W-1:0]       r_time;
    logic [SUM_W-1:0]        r_sq_x;
    logic [SUM_W-1:0]        r_sq_y;
    logic [SUM_W-1:0]        r_sq_z;
    logic signed [SUM_W-1:0] sq_x;
    logic signed [SUM_W-1:0] sq_y;
    logic signed [SUM_W-1:0] sq_z;
    logic                    accept;
    logic                    push_done;

    // Square each axis; results are never negative
    assign sq_x = i_accel_x * i_accel_x;
    assign sq_y = i_accel_y * i_accel_y;
    assign sq_z = i_accel_z * i_accel_z;

    // Hold the sample while the queue is full
    assign push_done  = r_valid && !i_q_full;
    assign o_in_stall = r_valid && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;

    // Sum the squares on the way into the queue
    assign o_push.valid        = r_valid;
    assign o_push.data.time_ms = r_time;
    assign o_push.data.sum_sq  = r_sq_x + r_sq_y + r_sq_z;

    // Stage valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (push_done) begin
            r_valid <= 1'b0;
        end
    end

    // Load squares on each transfer
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_time <= i_time_ms;
            r_sq_x <= $unsigned(sq_x);
            r_sq_y <= $unsigned(sq_y);
            r_sq_z <= $unsigned(sq_z);
        end
    end

endmodule

// ----- rtl/core/apsc_queue.sv -----
// ----------------------------------------------------------------------------
// apsc_queue: short sample queue
// Register FIFO between the intake and the step engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apsc_queue #(
    parameter int Q_DEPTH = apsc_pkg::Q_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  apsc_pkg::t_qpush i_push,
    input  logic             i_pop,
    output apsc_pkg::t_qstat o_stat
);
    import apsc_pkg::*;

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_QW = $clog2(Q_DEPTH + 1);
    localparam logic [PTR_W-1:0]  LAST_PTR = PTR_W'(Q_DEPTH - 1);
    localparam logic [CNT_QW-1:0] FULL_CNT = CNT_QW'(Q_DEPTH);

    t_qentry           r_mem [Q_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_QW-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_stat.full  = (r_count == FULL_CNT);
    assign o_stat.empty = (r_count == '0);
    assign o_stat.head  = r_mem[r_rd_ptr];

    assign do_push = i_push.valid && !o_stat.full;
    assign do_pop  = i_pop && !o_stat.empty;

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.data;
        end
    end

endmodule

// ----- rtl/core/apsc_back.sv -----
// ----------------------------------------------------------------------------
// apsc_back: step engine
// Takes queued samples, forms the magnitude with a bit-serial square root,
// tracks peaks and valleys, updates step counts and drives the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module apsc_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [apsc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [apsc_pkg::CFG_W-1:0]       i_cfg_data,
    input  apsc_pkg::t_qstat                 i_q_stat,
    output logic                             o_q_pop,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [apsc_pkg::TOTAL_W-1:0]     o_total_steps
);
    import apsc_pkg::*;

    localparam logic [SUM_W-1:0] ROOT_BIT0 = SUM_W'(1) << (SUM_W - 2);
    localparam logic [ROOT_CNT_W-1:0] ROOT_LAST = ROOT_CNT_W'(ROOT_STEPS - 1);
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Configuration registers
    logic [CFG_W-1:0] r_swing_thr;
    logic [CFG_W-1:0] r_fast_lim;
    logic [CFG_W-1:0] r_slow_lim;
    logic [CNT_W-1:0] r_confirm;

    // Sequencer and per-sample working registers
    t_back_state       r_state;
    t_back_state       n_state;
    logic [TIME_W-1:0] r_time;
    logic [SUM_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_res;
    logic [SUM_W-1:0]  r_bit;
    logic [ROOT_CNT_W-1:0] r_iter;
    logic              r_cand;
    logic [TIME_W-1:0] r_gap;

    // Detector state
    logic              r_falling;
    logic [MAG_W-1:0]  r_prev_mag;
    logic [MAG_W-1:0]  r_peak;
    logic [MAG_W-1:0]  r_valley;
    logic [TIME_W-1:0] r_last_step;
    logic [CNT_W-1:0]  r_pending;
    logic              r_walking;
    logic [TOTAL_W-1:0] r_total;

    // Result register
    logic               r_out_valid;
    logic [TOTAL_W-1:0] r_out_total;

    logic [SUM_W-1:0]  trial;
    logic              take_bit;
    logic [MAG_W-1:0]  mag;
    logic              is_peak;
    logic              is_valley;
    logic [MAG_W-1:0]  n_peak;
    logic [MAG_W-1:0]  n_valley;
    logic [MAG_W-1:0]  swing;
    logic              out_free;
    logic              too_fast;
    logic              too_slow;
    logic [CNT_W-1:0]  pend_inc;
    logic              n_walking;
    logic [TOTAL_W-1:0] n_total;
    logic [CNT_W-1:0]  n_pending;

    assign o_out_valid   = r_out_valid;
    assign o_total_steps = r_out_total;
    assign out_free      = !r_out_valid || !i_out_stall;
    assign o_q_pop       = (r_state == S_IDLE) && !i_q_stat.empty;

    // Square root step
    assign trial    = r_res + r_bit;
    assign take_bit = (r_rem >= trial);

    // Slope tracking
    assign mag       = r_res[MAG_W-1:0];
    assign is_peak   = !r_falling && (mag <= r_prev_mag);
    assign is_valley = r_falling && (mag > r_prev_mag);
    assign n_peak    = is_peak ? r_prev_mag : r_peak;
    assign n_valley  = is_valley ? r_prev_mag : r_valley;
    assign swing     = n_peak - n_valley;

    // Step decision
    assign too_fast  = r_gap < TIME_W'(r_fast_lim);
    assign too_slow  = r_gap > TIME_W'(r_slow_lim);
    assign pend_inc  = r_cand ? ((r_pending == CNT_MAX) ? CNT_MAX : r_pending + 1'b1)
                              : r_pending;
    assign n_walking = r_walking || (r_cand && (pend_inc >= r_confirm));
    assign n_total   = n_walking ? r_total + TOTAL_W'(pend_inc) : r_total;
    assign n_pending = n_walking ? '0 : pend_inc;

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                if (r_iter == ROOT_LAST) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swing_thr <= SWING_THR_RST;
            r_fast_lim  <= FAST_LIM_RST;
            r_slow_lim  <= SLOW_LIM_RST;
            r_confirm   <= CONFIRM_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SWING_THR: r_swing_thr <= i_cfg_data;
                CFG_FAST_LIM:  r_fast_lim  <= i_cfg_data;
                CFG_SLOW_LIM:  r_slow_lim  <= i_cfg_data;
                CFG_CONFIRM:   r_confirm   <= i_cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Load a sample and run the square root
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_time <= i_q_stat.head.time_ms;
            r_rem  <= i_q_stat.head.sum_sq;
            r_res  <= '0;
            r_bit  <= ROOT_BIT0;
            r_iter <= '0;
        end else if (r_state == S_ROOT) begin
            if (take_bit) begin
                r_rem <= r_rem - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit  <= r_bit >> 2;
            r_iter <= r_iter + 1'b1;
        end
    end

    // Register candidate flag and gap for the decision cycle
    always_ff @(posedge i_clk) begin
        if (r_state == S_EVAL) begin
            r_cand <= (is_peak || is_valley) && (swing > r_swing_thr);
            r_gap  <= r_time - r_last_step;
        end
    end

    // Detector and counter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_falling   <= 1'b0;
            r_prev_mag  <= '0;
            r_peak      <= '0;
            r_valley    <= '0;
            r_last_step <= '0;
            r_pending   <= '0;
            r_walking   <= 1'b0;
            r_total     <= '0;
        end else if (r_state == S_EVAL) begin
            if (is_peak) begin
                r_falling <= 1'b1;
            end else if (is_valley) begin
                r_falling <= 1'b0;
            end
            r_peak     <= n_peak;
            r_valley   <= n_valley;
            r_prev_mag <= mag;
        end else if ((r_state == S_COMMIT) && out_free) begin
            if (r_cand && too_fast) begin
                // drop: gap too short to be a step
            end else if (r_cand && too_slow) begin
                r_walking   <= 1'b0;
                r_pending   <= '0;
                r_last_step <= r_time;
            end else begin
                if (r_cand) begin
                    r_last_step <= r_time;
                end
                r_walking <= n_walking;
                r_pending <= n_pending;
                r_total   <= n_total;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_COMMIT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_COMMIT) && out_free) begin
            r_out_total <= (r_cand && (too_fast || too_slow)) ? r_total : n_total;
        end
    end

endmodule
